// ===== src/tcdq_pkg.sv =====
package tcdq_pkg;

    // Field widths of one tick item and one result item
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int CMD_W   = 32;

    // Bit offsets inside the slave-side tdata, lowest field first
    localparam int S_NOW_LO   = 0;
    localparam int S_DELAY_LO = S_NOW_LO + TIME_W;
    localparam int S_POS_LO   = S_DELAY_LO + DELAY_W;
    localparam int S_VEL_LO   = S_POS_LO + CMD_W;
    localparam int S_TDATA_W  = ((S_VEL_LO + CMD_W + 7) / 8) * 8;

    // Master-side tdata carries position then velocity; dropped travels in tuser
    localparam int M_TDATA_W = ((2 * CMD_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    localparam int QUEUE_DEPTH_DEF = 16;

endpackage

// ===== src/timestamped_command_delay_queue_unit.sv =====
// Timestamped command delay queue with sample hold.
//
// Slave channel (s_axis_*): one transfer per control tick, carrying the current
// time, a delay in ticks and a position/velocity command pair. The pair is
// stamped with release time now + delay (saturating) and appended to a queue
// of QUEUE_DEPTH entries; when the queue is full the pair is discarded and the
// result is flagged in tuser.
// Master channel (m_axis_*): exactly one result transfer per tick. It carries
// the pair of the last entry released on that tick, or the held pair when
// nothing fell due. Before the first release the held pair is the first
// tick's position with zero velocity.
// Timing: one item is worked on at a time. After acceptance the unit reads the
// queue head, then checks and releases due entries one by one (0 to QUEUE_DEPTH
// of them), then loads the result; the queue memory delivers one entry per cycle
// through its single registered read port.
// The result register parts the two sides: a new tick is accepted while the
// previous result still waits; if the receiver stalls, the next result holds
// in the final step until the register frees.
// Reset (synchronous, active low) empties the queue, clears the held pair's
// primed flag and drops any pending result. Queue contents are not cleared.
module timestamped_command_delay_queue_unit #(
    parameter int QUEUE_DEPTH = tcdq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // now_time[31:0], delay_ticks[47:32], position_cmd[79:48], velocity_cmd[111:80]
    input  logic [tcdq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // position_out[31:0], velocity_out[63:32]
    output logic [tcdq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // dropped[0]
    output logic [tcdq_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import tcdq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    typedef struct packed {
        logic [TIME_W-1:0] rel;
        logic [CMD_W-1:0]  pos;
        logic [CMD_W-1:0]  vel;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    // Queue storage: one synchronous memory, one write and one read port
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    t_state            r_state;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic [CW-1:0]     r_count;
    logic              r_primed;
    logic [TIME_W-1:0] r_now;
    logic [CMD_W-1:0]  r_held_pos;
    logic [CMD_W-1:0]  r_held_vel;
    logic              r_dropped;
    logic              r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;

    logic [TIME_W-1:0]  in_now;
    logic [DELAY_W-1:0] in_delay;
    logic [CMD_W-1:0]   in_pos;
    logic [CMD_W-1:0]   in_vel;
    logic [TIME_W:0]    rel_sum;
    logic [TIME_W-1:0]  rel_time;
    logic               accept;
    logic               full;
    logic               wr_en;
    logic               pop;
    logic               out_free;
    logic               load_out;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      tail_inc;
    logic [AW-1:0]      rd_addr;

    assign in_now   = s_axis_tdata[S_NOW_LO +: TIME_W];
    assign in_delay = s_axis_tdata[S_DELAY_LO +: DELAY_W];
    assign in_pos   = s_axis_tdata[S_POS_LO +: CMD_W];
    assign in_vel   = s_axis_tdata[S_VEL_LO +: CMD_W];

    // Saturate the release time at the top of the time range
    assign rel_sum  = {1'b0, in_now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, in_delay};
    assign rel_time = rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (r_count == CNT_FULL);
    assign wr_en         = accept && !full;

    assign head_inc = (r_head == IDX_LAST) ? '0 : r_head + AW'(1);
    assign tail_inc = (r_tail == IDX_LAST) ? '0 : r_tail + AW'(1);

    // Release the head while it is due; stop at the first entry not yet due
    assign pop = (r_state == ST_CHECK) && (r_count != '0) && (r_rd_data.rel <= r_now);

    // Read ahead on a release so the next head is ready in the following cycle
    assign rd_addr  = pop ? head_inc : r_head;
    assign out_free = !r_out_valid || m_axis_tready;
    assign load_out = (r_state == ST_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= '{rel: rel_time, pos: in_pos, vel: in_vel};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result or drop the one just taken
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_now <= in_now;
                        if (!r_primed) begin
                            r_held_pos <= in_pos;
                            r_held_vel <= '0;
                            r_primed   <= 1'b1;
                        end
                        if (full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_dropped <= 1'b0;
                            r_tail    <= tail_inc;
                            r_count   <= r_count + CW'(1);
                        end
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    // head entry is being read; the push has landed by now
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (pop) begin
                        r_held_pos <= r_rd_data.pos;
                        r_held_vel <= r_rd_data.vel;
                        r_head     <= head_inc;
                        r_count    <= r_count - CW'(1);
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold here while the previous result is still stalled
                    if (load_out) begin
                        r_out_data <= {r_held_vel, r_held_pos};
                        r_out_user <= r_dropped;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== src/tcdq_checker.sv =====
module tcdq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [tcdq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tcdq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [tcdq_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import tcdq_pkg::*;

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // One tick at a time: the input closes for the cycle after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input ready straight after a transfer");

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // A tick's result cannot leave in the cycle right after that tick arrives
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind timestamped_command_delay_queue_unit tcdq_checker u_tcdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tcdq_sb_pkg.sv =====
`timescale 1ns / 100ps

package tcdq_sb_pkg;

    import tcdq_pkg::*;

    // One control tick as offered on the slave side
    typedef struct {
        logic [TIME_W-1:0]         now_time;
        logic [DELAY_W-1:0]        delay_ticks;
        logic signed [CMD_W-1:0]   position_cmd;
        logic signed [CMD_W-1:0]   velocity_cmd;
    } t_tick;

    // A command pair waiting for its release time
    typedef struct {
        logic [TIME_W-1:0]         release_at;
        logic signed [CMD_W-1:0]   pos;
        logic signed [CMD_W-1:0]   vel;
    } t_queued_cmd;

    // What the actuator side should see for one tick
    typedef struct {
        logic signed [CMD_W-1:0]   pos;
        logic signed [CMD_W-1:0]   vel;
        logic                      dropped;
    } t_actuator_cmd;

    class cmd_delay_scoreboard;
        t_queued_cmd             queued_cmds[$];
        t_actuator_cmd           due_outputs[$];
        logic signed [CMD_W-1:0] held_pos = '0;
        logic signed [CMD_W-1:0] held_vel = '0;
        bit                      primed   = 1'b0;
        int                      errors   = 0;
        int                      compared = 0;
        int                      ticks    = 0;
        int                      drops    = 0;
        int                      released = 0;
        int                      saturated = 0;

        task flag_mismatch(string what);
            if (errors < 50)
                $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // Advance the delay queue by one accepted tick and note the pair it emits
        function void note_tick(t_tick t);
            logic [TIME_W:0] sum;
            t_queued_cmd     entry;
            t_actuator_cmd   outp;
            sum              = {1'b0, t.now_time}
                             + {{(TIME_W + 1 - DELAY_W){1'b0}}, t.delay_ticks};
            entry.release_at = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            entry.pos        = t.position_cmd;
            entry.vel        = t.velocity_cmd;
            if (sum[TIME_W])
                saturated++;
            ticks++;
            if (!primed) begin
                held_pos = t.position_cmd;
                held_vel = '0;
                primed   = 1'b1;
            end
            outp.dropped = 1'b0;
            if (queued_cmds.size() >= QUEUE_DEPTH_DEF) begin
                outp.dropped = 1'b1;
                drops++;
            end else begin
                queued_cmds.insert(queued_cmds.size(), entry);
            end
            outp.pos = held_pos;
            outp.vel = held_vel;
            // Release in order; stop at the first entry not yet due
            while (queued_cmds.size() > 0 && queued_cmds[0].release_at <= t.now_time) begin
                outp.pos = queued_cmds[0].pos;
                outp.vel = queued_cmds[0].vel;
                queued_cmds.delete(0);
                released++;
            end
            held_pos = outp.pos;
            held_vel = outp.vel;
            due_outputs.insert(due_outputs.size(), outp);
        endfunction

        task check_result(logic signed [CMD_W-1:0] pos, logic signed [CMD_W-1:0] vel,
                          logic dropped);
            t_actuator_cmd want;
            if (due_outputs.size() == 0) begin
                flag_mismatch($sformatf("result with no tick pending: pos %h vel %h drop %b",
                                        pos, vel, dropped));
                return;
            end
            want = due_outputs[0];
            due_outputs.delete(0);
            compared++;
            if (pos !== want.pos)
                flag_mismatch($sformatf("result %0d position %h, want %h",
                                        compared, pos, want.pos));
            if (vel !== want.vel)
                flag_mismatch($sformatf("result %0d velocity %h, want %h",
                                        compared, vel, want.vel));
            if (dropped !== want.dropped)
                flag_mismatch($sformatf("result %0d dropped %b, want %b",
                                        compared, dropped, want.dropped));
        endtask
    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import tcdq_pkg::*;
    import tcdq_sb_pkg::*;

    localparam int RANDOM_TICKS = 550;
    localparam int DRAIN_LIMIT  = 5000;   // cycles to wait for outstanding results
    localparam int TAIL_CYCLES  = 40;

    typedef enum int {
        RUN_STEADY,   // slowly advancing time, short delays
        RUN_CONGEST,  // time barely moves, long delays: fills the queue
        RUN_NOISE     // any time, any delay
    } t_run_kind;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // now_time[31:0], delay_ticks[47:32], position_cmd[79:48], velocity_cmd[111:80]
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // position_out[31:0], velocity_out[63:32]
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    // dropped[0]
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    cmd_delay_scoreboard    sb = new();

    // Idling rates, changed per run; both drop to zero for the closing stretch
    int                     send_gap_pct    = 0;
    int                     ready_stall_pct = 0;

    timestamped_command_delay_queue_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake locks up
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one tick, optionally after an idle burst, and hold it until the
    // transfer completes. Returns right after the accepting edge, so the next
    // call may keep tvalid high without a glitch.
    task automatic send_tick(input logic [TIME_W-1:0] now, input logic [DELAY_W-1:0] dly,
                             input logic [CMD_W-1:0] pos, input logic [CMD_W-1:0] vel);
        logic [S_TDATA_W-1:0] word;
        t_tick                t;
        int                   gap;
        word                                 = '0;
        word[S_NOW_LO   +: TIME_W]           = now;
        word[S_DELAY_LO +: DELAY_W]          = dly;
        word[S_POS_LO   +: CMD_W]            = pos;
        word[S_VEL_LO   +: CMD_W]            = vel;
        t.now_time     = now;
        t.delay_ticks  = dly;
        t.position_cmd = pos;
        t.velocity_cmd = vel;
        if ($urandom_range(0, 99) < send_gap_pct) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(t);
    endtask

    // Receiver: check each result transfer, then decide tready for the next edge
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[0 +: CMD_W], m_axis_tdata[CMD_W +: CMD_W],
                                m_axis_tuser[0]);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < ready_stall_pct) begin
                // begin a stalled burst, this cycle included; the rest count down in stall_left
                stall_left    = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [TIME_W-1:0]  cur_time;
        logic [DELAY_W-1:0] dly;
        t_run_kind          kind;
        int                 run_len;
        int                 sent_random;
        int                 pick;
        int                 guard;
        bit                 needs_flush;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed part ----
        // First tick primes the held pair: its position with zero velocity
        send_tick(32'd100, 16'd5, 32'h7FFF_FFFF, 32'h8000_0000);
        // Zero delay, but the older entry at the head is not yet due: hold
        send_tick(32'd101, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Everything due at once: release three and output the newest
        send_tick(32'd105, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        // Release time saturates at the top of the time range
        send_tick(32'hFFFF_FFF0, 16'hFFFF, 32'h0000_0001, 32'hFFFF_FFFE);
        send_tick(32'hFFFF_FFFF, 16'd5, 32'h5555_5555, 32'hAAAA_AAAA);
        // Time steps backward: the late head blocks the already-due entry
        send_tick(32'd50, 16'hFFFF, 32'h0000_0000, 32'h0000_0000);
        send_tick(32'd10, 16'd0, 32'h1234_5678, 32'h8765_4321);
        send_tick(32'h0002_0000, 16'd0, 32'hAAAA_AAAA, 32'h5555_5555);
        // Fill the queue, overflow it once, then release while still full
        for (int k = 0; k < QUEUE_DEPTH_DEF + 1; k++)
            send_tick(32'd1000 + k, 16'hFFFF, $urandom, $urandom);
        send_tick(32'd70000, 16'd0, $urandom, $urandom);

        // ---- Random part ----
        cur_time    = 32'd70000;
        sent_random = 0;
        while (sent_random < RANDOM_TICKS) begin
            pick        = $urandom_range(0, 9);
            kind        = (pick < 6) ? RUN_STEADY : (pick < 8) ? RUN_CONGEST : RUN_NOISE;
            run_len     = $urandom_range(8, 40);
            needs_flush = (kind == RUN_NOISE);
            // Closing stretch: no idling on either side
            if (sent_random >= RANDOM_TICKS * 85 / 100) begin
                send_gap_pct    = 0;
                ready_stall_pct = 0;
            end else begin
                send_gap_pct    = $urandom_range(0, 2) * 25;
                ready_stall_pct = $urandom_range(0, 2) * 25;
            end
            // Now and then run up against the top of the time range
            if (kind == RUN_STEADY && $urandom_range(0, 7) == 0) begin
                cur_time    = 32'hFFFF_FF00 + $urandom_range(0, 200);
                needs_flush = 1'b1;
            end
            for (int k = 0; k < run_len && sent_random < RANDOM_TICKS; k++) begin
                case (kind)
                    RUN_STEADY: begin
                        cur_time = cur_time + $urandom_range(0, 4);
                        dly      = DELAY_W'($urandom_range(0, 30));
                        send_tick(cur_time, dly, $urandom, $urandom);
                    end
                    RUN_CONGEST: begin
                        cur_time = cur_time + $urandom_range(0, 1);
                        dly      = DELAY_W'($urandom_range(20, 60));
                        send_tick(cur_time, dly, $urandom, $urandom);
                    end
                    default: begin
                        dly = DELAY_W'($urandom_range(0, 16'hFFFF));
                        send_tick($urandom, dly, $urandom, $urandom);
                    end
                endcase
                sent_random++;
            end
            // Drain whatever far-future entries the run left: every release
            // time is at or below the top of the range
            if (needs_flush) begin
                dly = DELAY_W'($urandom_range(0, 16'hFFFF));
                send_tick(32'hFFFF_FFFF, dly, $urandom, $urandom);
                sent_random++;
                cur_time = $urandom_range(0, 32'h000F_FFFF);
            end
        end
        s_axis_tvalid <= 1'b0;

        // ---- Wind down ----
        guard = 0;
        while (sb.due_outputs.size() > 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.due_outputs.size() > 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.due_outputs.size()));

        $display("Ran %0d ticks and compared %0d results: %0d commands released,",
                 sb.ticks, sb.compared, sb.released);
        $display("%0d ticks dropped on a full queue, %0d release times saturated.",
                 sb.drops, sb.saturated);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
